// ===== sv/i2cmt_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmt_pkg
// Shared types and constants of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cmt_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned BITCNT_W       = 4;
    localparam int unsigned S_TDATA_W      = 32;
    localparam int unsigned M_TDATA_W      = 16;

    localparam logic [BYTE_W-1:0]   ACK_WINDOW_RESET = 8'd5;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE    = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_LOW  = 4'd1,
        PH_W_SETUP    = 4'd2,
        PH_W_HIGH     = 4'd3,
        PH_ACK_REL    = 4'd4,
        PH_ACK_WAIT   = 4'd5,
        PH_R_LOW      = 4'd6,
        PH_R_HIGH     = 4'd7,
        PH_MA_LOW     = 4'd8,
        PH_MA_HIGH    = 4'd9,
        PH_STOP_LOW   = 4'd10,
        PH_STOP_HIGH  = 4'd11,
        PH_STOP_END   = 4'd12,
        PH_ASTOP_LOW  = 4'd13,
        PH_ASTOP_HIGH = 4'd14,
        PH_ASTOP_END  = 4'd15
    } phase_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] wr_bytes;
        logic [BYTE_W-1:0] rd_bytes;
        logic [BYTE_W-1:0] tx_byte;
        logic              sda_in;
    } tick_t;

    typedef struct packed {
        logic              nack_abort;
        logic              done_res;
        logic              busy_res;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_taken;
        logic              sda_released;
        logic              sda_level;
        logic              scl_level;
    } result_t;

endpackage

// ===== sv/i2cmt_seq.sv =====
// ----------------------------------------------------------------------------
// i2cmt_seq
// Phase sequencer: bus state registers plus the per-tick next state and pin
// levels. State advances only on a step.
// ----------------------------------------------------------------------------
module i2cmt_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  i2cmt_pkg::tick_t                 tick,
    input  logic [i2cmt_pkg::BYTE_W-1:0]     ack_window,
    output i2cmt_pkg::result_t               result
);
    import i2cmt_pkg::*;

    phase_t              phase_reg,       phase_next;
    logic [BITCNT_W-1:0] bit_cnt_reg,     bit_cnt_next;
    logic [BYTE_W-1:0]   shift_reg,       shift_next;
    logic [BYTE_W-1:0]   writes_left_reg, writes_left_next;
    logic [BYTE_W-1:0]   reads_left_reg,  reads_left_next;
    logic [BYTE_W-1:0]   ack_timer_reg,   ack_timer_next;
    logic                ack_seen_reg,    ack_seen_next;

    logic [BITCNT_W-1:0] bit_cnt_inc;
    logic [BYTE_W-1:0]   writes_dec;
    logic [BYTE_W-1:0]   reads_dec;
    logic [BYTE_W-1:0]   shift_in;
    logic                ack_now;
    phase_t              after_writes;
    phase_t              after_ack;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            bit_cnt_reg     <= '0;
            shift_reg       <= '0;
            writes_left_reg <= '0;
            reads_left_reg  <= '0;
            ack_timer_reg   <= '0;
            ack_seen_reg    <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            bit_cnt_reg     <= bit_cnt_next;
            shift_reg       <= shift_next;
            writes_left_reg <= writes_left_next;
            reads_left_reg  <= reads_left_next;
            ack_timer_reg   <= ack_timer_next;
            ack_seen_reg    <= ack_seen_next;
        end
    end

    always_comb begin
        bit_cnt_inc = bit_cnt_reg + 1'b1;
        writes_dec  = (writes_left_reg != '0) ? writes_left_reg - 1'b1 : writes_left_reg;
        reads_dec   = (reads_left_reg != '0) ? reads_left_reg - 1'b1 : reads_left_reg;
        shift_in    = {shift_reg[BYTE_W-2:0], tick.sda_in};
        ack_now     = ack_seen_reg | ~tick.sda_in;

        if (writes_left_reg != '0) begin
            after_writes = PH_W_SETUP;
        end else if (reads_left_reg != '0) begin
            after_writes = PH_R_LOW;
        end else begin
            after_writes = PH_STOP_LOW;
        end

        if (writes_dec != '0) begin
            after_ack = PH_W_SETUP;
        end else if (reads_left_reg != '0) begin
            after_ack = PH_R_LOW;
        end else begin
            after_ack = PH_STOP_LOW;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        bit_cnt_next     = bit_cnt_reg;
        shift_next       = shift_reg;
        writes_left_next = writes_left_reg;
        reads_left_next  = reads_left_reg;
        ack_timer_next   = ack_timer_reg;
        ack_seen_next    = ack_seen_reg;

        result              = '0;
        result.scl_level    = 1'b1;
        result.sda_level    = 1'b1;
        result.busy_res     = 1'b1;

        unique case (phase_reg)
            PH_START_LOW: begin
                result.scl_level = 1'b0;
                result.sda_level = 1'b0;
                bit_cnt_next     = '0;
                phase_next       = after_writes;
            end
            PH_W_SETUP: begin
                result.scl_level = 1'b0;
                if (bit_cnt_reg == '0) begin
                    shift_next       = tick.tx_byte;
                    result.tx_taken  = 1'b1;
                    result.sda_level = tick.tx_byte[BYTE_W-1];
                end else begin
                    result.sda_level = shift_reg[BYTE_W-1];
                end
                phase_next = PH_W_HIGH;
            end
            PH_W_HIGH: begin
                result.sda_level = shift_reg[BYTE_W-1];
                shift_next       = {shift_reg[BYTE_W-2:0], 1'b0};
                if (bit_cnt_inc >= BITS_PER_BYTE) begin
                    bit_cnt_next = '0;
                    phase_next   = PH_ACK_REL;
                end else begin
                    bit_cnt_next = bit_cnt_inc;
                    phase_next   = PH_W_SETUP;
                end
            end
            PH_ACK_REL: begin
                result.scl_level    = 1'b0;
                result.sda_released = 1'b1;
                ack_timer_next      = (ack_window != '0) ? ack_window : BYTE_W'(1);
                ack_seen_next       = 1'b0;
                phase_next          = PH_ACK_WAIT;
            end
            PH_ACK_WAIT: begin
                result.sda_released = 1'b1;
                ack_seen_next       = ack_now;
                if (ack_timer_reg <= BYTE_W'(1)) begin
                    ack_timer_next = '0;
                    if (ack_now) begin
                        writes_left_next = writes_dec;
                        phase_next       = after_ack;
                    end else begin
                        phase_next = PH_ASTOP_LOW;
                    end
                end else begin
                    ack_timer_next = ack_timer_reg - 1'b1;
                end
            end
            PH_R_LOW: begin
                result.scl_level    = 1'b0;
                result.sda_released = 1'b1;
                phase_next          = PH_R_HIGH;
            end
            PH_R_HIGH: begin
                result.sda_released = 1'b1;
                shift_next          = shift_in;
                if (bit_cnt_inc >= BITS_PER_BYTE) begin
                    bit_cnt_next    = '0;
                    result.rx_byte  = shift_in;
                    result.rx_valid = 1'b1;
                    reads_left_next = reads_dec;
                    phase_next      = PH_MA_LOW;
                end else begin
                    bit_cnt_next = bit_cnt_inc;
                    phase_next   = PH_R_LOW;
                end
            end
            PH_MA_LOW: begin
                result.scl_level = 1'b0;
                result.sda_level = (reads_left_reg == '0);
                phase_next       = PH_MA_HIGH;
            end
            PH_MA_HIGH: begin
                result.sda_level = (reads_left_reg == '0);
                phase_next       = (reads_left_reg != '0) ? PH_R_LOW : PH_STOP_LOW;
            end
            PH_STOP_LOW, PH_ASTOP_LOW: begin
                result.scl_level = 1'b0;
                result.sda_level = 1'b0;
                phase_next = (phase_reg == PH_STOP_LOW) ? PH_STOP_HIGH : PH_ASTOP_HIGH;
            end
            PH_STOP_HIGH, PH_ASTOP_HIGH: begin
                result.sda_level = 1'b0;
                phase_next = (phase_reg == PH_STOP_HIGH) ? PH_STOP_END : PH_ASTOP_END;
            end
            PH_STOP_END, PH_ASTOP_END: begin
                result.done_res   = 1'b1;
                result.nack_abort = (phase_reg == PH_ASTOP_END);
                writes_left_next  = '0;
                reads_left_next   = '0;
                phase_next        = PH_IDLE;
            end
            PH_IDLE: begin
                if (tick.op) begin
                    writes_left_next = tick.wr_bytes;
                    reads_left_next  = tick.rd_bytes;
                    bit_cnt_next     = '0;
                    ack_seen_next    = 1'b0;
                    ack_timer_next   = '0;
                    result.sda_level = 1'b0;
                    phase_next       = PH_START_LOW;
                end else begin
                    result.busy_res = 1'b0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (result.sda_released) begin
            result.sda_level = 1'b1;
        end
    end

endmodule

// ===== sv/i2c_master_transaction_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_top
// I2C master transaction sequencer, one bus phase per transfer.
// ----------------------------------------------------------------------------
// Each s_ transfer is one bus phase tick carrying the sampled SDA level and,
// on a begin tick, the write and read byte counts. Each tick yields exactly
// one m_ transfer with the SCL/SDA levels, tx byte take strobe, received
// byte and busy/done/abort flags.
// cfg_ channel writes the ack window length (ticks SCL is held high waiting
// for the slave ACK); it is always ready and should only be written while
// the bus is idle.
// A transferred tick waits in the input register; its phase update is
// combinational, and the result enters the output register once the
// output is free. Throughput: one tick per cycle while m_ is not stalled,
// set by the phase update between the input and output registers.
// Reset clears both valid flags and returns the bus to idle, both lines
// high, ack window 5. When m_tready is low the output holds, an empty input
// register still takes one more tick, then s_tready drops until m_ drains.
// ----------------------------------------------------------------------------
module i2c_master_transaction_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // [7:0] wr_bytes, [15:8] rd_bytes, [23:16] tx_byte, [24] sda_in
    input  logic [i2cmt_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] op
    input  logic [0:0]                           s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [0] scl_level, [1] sda_level, [2] sda_released, [3] tx_taken,
    // [11:4] rx_byte, [12] rx_valid, [13] busy_res, [14] done_res,
    // [15] nack_abort
    output logic [i2cmt_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [i2cmt_pkg::BYTE_W-1:0]         cfg_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready
);
    import i2cmt_pkg::*;

    tick_t             in_reg,        in_next;
    logic              in_valid_reg,  in_valid_next;
    result_t           out_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] ack_window_reg;
    result_t           result;
    logic              out_free;
    logic              step;
    logic              s_xfer;

    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_next.op       = s_tuser[0];
        in_next.wr_bytes = s_tdata[7:0];
        in_next.rd_bytes = s_tdata[15:8];
        in_next.tx_byte  = s_tdata[23:16];
        in_next.sda_in   = s_tdata[24];

        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ack_window_reg <= ACK_WINDOW_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                ack_window_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg <= in_next;
        end
        if (step) begin
            out_reg <= result;
        end
    end

    i2cmt_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .tick       (in_reg),
        .ack_window (ack_window_reg),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
